// ===== hdl/ffba_pkg.sv =====
package ffba_pkg;

    localparam int HEAP_WORDS_DEF = 1024;
    localparam int WORD_W         = 10;
    localparam int HDR_W          = 16;
    localparam int BYTE_W         = 12;
    localparam int NEED_W         = 13;
    localparam int MAX_HEAP_BYTES = 4084;
    localparam int INIT_OVH       = 12;
    localparam int HDR_BYTES      = 4;
    localparam int MIN_BLOCK      = 8;
    localparam int ALIGN_MASK     = 7;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [HDR_W-1:0]  t_hdr;

    typedef enum logic [1:0] {
        MD_ALLOC = 2'd0,
        MD_FREE  = 2'd1,
        MD_MERGE = 2'd2,
        MD_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_DBLFREE = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef struct packed {
        logic    idle;
        logic    done;
        t_status status;
        logic    init_clr;
    } t_ctrl_stat;

    function automatic t_word blk_next(input t_word w, input t_hdr hdr, input t_word sent);
        logic [14:0] n;
        n = 15'(w) + 15'({hdr[HDR_W-1:3], 1'b0});
        if (hdr[HDR_W-1:3] == '0 || n > 15'(sent)) begin
            return sent;
        end
        return n[WORD_W-1:0];
    endfunction

endpackage

// ===== hdl/first_fit_block_allocator.sv =====
// First-fit heap allocator over a registered-read header RAM of HEAP_WORDS 16-bit words.
// One item is in flight at a time; the result sits in an output register so the next item
// can be taken while it waits. An allocate walks block headers from word 1 at one header
// read per cycle. A coalesce reads one header per cycle but pauses in S_MNX after each
// merge; a free reads the block's header and clears its taken bit. The first item after
// reset or after a heap_bytes write first lays down the heap in S_INIT1 and S_INIT2 (first
// block, then sentinel). Configuration writes are taken only while no item is in progress.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF,
    localparam int AW = $clog2(HEAP_WORDS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [BYTE_W-1:0] i_request_bytes,
    input  logic [BYTE_W-1:0] i_payload_offset,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BYTE_W-1:0] i_heap_bytes
);

    t_ctrl_stat        s_ctrl;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    t_hdr              wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    t_hdr              rd_data;
    logic              out_free;

    logic              r_out_valid;
    t_status           r_status;
    logic [BYTE_W-1:0] r_heap_bytes;
    logic              r_init_pend;

    assign out_free = !r_out_valid || !i_out_stall;

    ffba_ctrl #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_mode           (i_mode),
        .i_request_bytes  (i_request_bytes),
        .i_payload_offset (i_payload_offset),
        .i_heap_bytes     (r_heap_bytes),
        .i_init_pend      (r_init_pend),
        .i_out_free       (out_free),
        .o_stat           (s_ctrl),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data)
    );

    ffba_ram #(
        .DEPTH (HEAP_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_heap_bytes <= BYTE_W'(MAX_HEAP_BYTES);
            r_init_pend  <= 1'b1;
        end else begin
            if (s_ctrl.done && out_free) begin
                r_out_valid <= 1'b1;
                r_status    <= s_ctrl.status;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_heap_bytes <= i_heap_bytes;
                r_init_pend  <= 1'b1;
            end else if (s_ctrl.init_clr) begin
                r_init_pend <= 1'b0;
            end
        end
    end

    assign o_in_stall  = !s_ctrl.idle;
    assign o_cfg_ready = s_ctrl.idle;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted but controller did not go busy");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_ctrl.done && !r_out_valid) |=> (r_out_valid && r_status == $past(s_ctrl.status)))
        else $error("finished result not loaded into output register");

    a_init_only_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctrl.init_clr |-> r_init_pend)
        else $error("heap laid down without a pending initialization");

endmodule

// ===== hdl/ffba_ram.sv =====
module ffba_ram
    import ffba_pkg::*;
#(
    parameter int DEPTH = HEAP_WORDS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_hdr          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_hdr          o_rd_data
);

    t_hdr r_mem [DEPTH];
    t_hdr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ffba_ctrl.sv =====
module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF,
    localparam int AW = $clog2(HEAP_WORDS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    input  logic [BYTE_W-1:0] i_request_bytes,
    input  logic [BYTE_W-1:0] i_payload_offset,
    input  logic [BYTE_W-1:0] i_heap_bytes,
    input  logic              i_init_pend,
    input  logic              i_out_free,
    output t_ctrl_stat        o_stat,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output t_hdr              o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  t_hdr              i_rd_data
);

    localparam int CAP = HEAP_WORDS * 4 - INIT_OVH;
    localparam int LIM = (CAP < MAX_HEAP_BYTES) ? CAP : MAX_HEAP_BYTES;
    localparam int IW  = ((AW > BYTE_W) ? AW : BYTE_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT1,
        S_INIT2,
        S_DISP,
        S_AWALK,
        S_ASPLIT,
        S_AREM,
        S_FREE,
        S_MW,
        S_MN,
        S_MNX,
        S_DONE
    } t_state;

    function automatic logic [AW-1:0] to_addr(input logic [BYTE_W-1:0] v);
        logic [IW-1:0] x;
        x = IW'(v);
        if (x >= IW'(HEAP_WORDS)) begin
            x = x - IW'(HEAP_WORDS);
        end
        return x[AW-1:0];
    endfunction

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [BYTE_W-1:0]   r_req, n_req;
    logic [BYTE_W-1:0]   r_off, n_off;
    logic [NEED_W-1:0]   r_need, n_need;
    t_word               r_w, n_w;
    t_word               r_n, n_n;
    t_hdr                r_hdr, n_hdr;
    t_word               r_sent, n_sent;
    t_status             r_res, n_res;

    logic [BYTE_W-1:0]   size;
    logic [NEED_W-1:0]   total;
    logic [NEED_W-1:0]   hdr1;
    t_word               sent_new;
    logic [NEED_W-1:0]   need_calc;
    t_word               free_w;
    logic                free_bad;
    t_hdr                rd_len;
    t_hdr                hdr_len;
    t_hdr                rem;
    t_hdr                sum;
    logic [BYTE_W-1:0]   rem_idx;
    t_word               nx_rd_w;
    t_word               nx_rd_n;
    t_word               nx_hdr_w;
    t_word               rd_idx;
    logic [BYTE_W-1:0]   wr_idx;
    logic                init_clr;

    assign size      = (i_heap_bytes > BYTE_W'(LIM)) ? BYTE_W'(LIM) : i_heap_bytes;
    assign total     = (NEED_W'(size) + NEED_W'(INIT_OVH) + NEED_W'(ALIGN_MASK))
                       & ~NEED_W'(ALIGN_MASK);
    assign hdr1      = total - NEED_W'(MIN_BLOCK);
    assign sent_new  = WORD_W'(hdr1[NEED_W-1:2] + 11'(1));

    assign need_calc = (NEED_W'(r_req) + NEED_W'(HDR_BYTES) + NEED_W'(ALIGN_MASK))
                       & ~NEED_W'(ALIGN_MASK);
    assign free_w    = r_off[BYTE_W-1:2] - WORD_W'(1);
    assign free_bad  = (r_off[2:0] != '0) || (r_off < BYTE_W'(MIN_BLOCK)) || (free_w >= r_sent);

    assign rd_len    = {i_rd_data[HDR_W-1:3], 3'b000};
    assign hdr_len   = {r_hdr[HDR_W-1:3], 3'b000};
    assign rem       = hdr_len - HDR_W'(r_need);
    assign sum       = hdr_len + rd_len;
    assign rem_idx   = BYTE_W'(r_w) + BYTE_W'(r_need[NEED_W-1:2]);
    assign nx_rd_w   = blk_next(r_w, i_rd_data, r_sent);
    assign nx_rd_n   = blk_next(r_n, i_rd_data, r_sent);
    assign nx_hdr_w  = blk_next(r_w, r_hdr, r_sent);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_req     = r_req;
        n_off     = r_off;
        n_need    = r_need;
        n_w       = r_w;
        n_n       = r_n;
        n_hdr     = r_hdr;
        n_sent    = r_sent;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        rd_idx    = '0;
        o_wr_en   = 1'b0;
        wr_idx    = '0;
        o_wr_data = '0;
        init_clr  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = t_mode'(i_mode);
                    n_req   = i_request_bytes;
                    n_off   = i_payload_offset;
                    n_state = i_init_pend ? S_INIT1 : S_DISP;
                end
            end
            S_INIT1: begin
                o_wr_en   = 1'b1;
                wr_idx    = BYTE_W'(1);
                o_wr_data = HDR_W'(hdr1);
                n_state   = S_INIT2;
            end
            S_INIT2: begin
                o_wr_en   = 1'b1;
                wr_idx    = BYTE_W'(sent_new);
                o_wr_data = '0;
                n_sent    = sent_new;
                init_clr  = 1'b1;
                n_state   = S_DISP;
            end
            S_DISP: begin
                case (r_mode)
                    MD_ALLOC: begin
                        n_need  = need_calc;
                        n_w     = WORD_W'(1);
                        o_rd_en = 1'b1;
                        rd_idx  = WORD_W'(1);
                        n_state = S_AWALK;
                    end
                    MD_FREE: begin
                        if (free_bad) begin
                            n_res   = ST_RANGE;
                            n_state = S_DONE;
                        end else begin
                            n_w     = free_w;
                            o_rd_en = 1'b1;
                            rd_idx  = free_w;
                            n_state = S_FREE;
                        end
                    end
                    MD_MERGE: begin
                        n_w     = WORD_W'(1);
                        o_rd_en = 1'b1;
                        rd_idx  = WORD_W'(1);
                        n_state = S_MW;
                    end
                    default: begin
                        n_res   = ST_OK;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_AWALK: begin
                if (r_w == r_sent) begin
                    n_res   = ST_NOSPACE;
                    n_state = S_DONE;
                end else if (rd_len >= HDR_W'(r_need) && !i_rd_data[0]) begin
                    n_hdr   = i_rd_data;
                    n_state = S_ASPLIT;
                end else begin
                    n_w     = nx_rd_w;
                    o_rd_en = 1'b1;
                    rd_idx  = nx_rd_w;
                end
            end
            S_ASPLIT: begin
                o_wr_en = 1'b1;
                wr_idx  = BYTE_W'(r_w);
                if (rem >= HDR_W'(MIN_BLOCK)) begin
                    o_wr_data = HDR_W'(r_need) | HDR_W'(1);
                    n_state   = S_AREM;
                end else begin
                    o_wr_data = r_hdr | HDR_W'(1);
                    n_res     = ST_OK;
                    n_state   = S_DONE;
                end
            end
            S_AREM: begin
                o_wr_en   = 1'b1;
                wr_idx    = rem_idx;
                o_wr_data = rem;
                n_res     = ST_OK;
                n_state   = S_DONE;
            end
            S_FREE: begin
                if (!i_rd_data[0]) begin
                    n_res = ST_DBLFREE;
                end else begin
                    o_wr_en   = 1'b1;
                    wr_idx    = BYTE_W'(r_w);
                    o_wr_data = i_rd_data & ~HDR_W'(1);
                    n_res     = ST_OK;
                end
                n_state = S_DONE;
            end
            S_MW: begin
                n_hdr = i_rd_data;
                if (nx_rd_w == r_sent) begin
                    n_res   = ST_OK;
                    n_state = S_DONE;
                end else begin
                    n_n     = nx_rd_w;
                    o_rd_en = 1'b1;
                    rd_idx  = nx_rd_w;
                    n_state = S_MN;
                end
            end
            S_MN: begin
                if (!r_hdr[0] && !i_rd_data[0]) begin
                    o_wr_en   = 1'b1;
                    wr_idx    = BYTE_W'(r_w);
                    o_wr_data = sum;
                    n_hdr     = sum;
                    n_state   = S_MNX;
                end else begin
                    n_w   = r_n;
                    n_hdr = i_rd_data;
                    if (nx_rd_n == r_sent) begin
                        n_res   = ST_OK;
                        n_state = S_DONE;
                    end else begin
                        n_n     = nx_rd_n;
                        o_rd_en = 1'b1;
                        rd_idx  = nx_rd_n;
                    end
                end
            end
            S_MNX: begin
                if (nx_hdr_w == r_sent) begin
                    n_res   = ST_OK;
                    n_state = S_DONE;
                end else begin
                    n_n     = nx_hdr_w;
                    o_rd_en = 1'b1;
                    rd_idx  = nx_hdr_w;
                    n_state = S_MN;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mode <= n_mode;
        r_req  <= n_req;
        r_off  <= n_off;
        r_need <= n_need;
        r_w    <= n_w;
        r_n    <= n_n;
        r_hdr  <= n_hdr;
        r_sent <= n_sent;
        r_res  <= n_res;
    end

    assign o_rd_addr       = to_addr(BYTE_W'(rd_idx));
    assign o_wr_addr       = to_addr(wr_idx);
    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.done     = (r_state == S_DONE);
    assign o_stat.status   = r_res;
    assign o_stat.init_clr = init_clr;

endmodule

// ===== tb/first_fit_block_allocator_test.sv =====
module first_fit_block_allocator_test;
    import ffba_pkg::*;

    localparam int HW         = HEAP_WORDS_DEF;
    localparam int IDLE_LIMIT = 8000;

    typedef struct packed {
        t_mode             mode;
        logic [BYTE_W-1:0] req;
        logic [BYTE_W-1:0] off;
    } t_heap_cmd;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_mode = '0;
    logic [BYTE_W-1:0] i_request_bytes = '0;
    logic [BYTE_W-1:0] i_payload_offset = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_status;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [BYTE_W-1:0] i_heap_bytes = '0;

    first_fit_block_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_request_bytes (i_request_bytes),
        .i_payload_offset(i_payload_offset),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_heap_bytes    (i_heap_bytes)
    );

    always #1 i_clk = ~i_clk;

    bit [HDR_W-1:0] heap_hdr [HW];
    bit             hdr_written [HW];
    int             sent_word;
    bit             relay_due = 1'b1;
    int             heap_size_req = MAX_HEAP_BYTES;

    t_heap_cmd pending_words [$];
    t_status   status_due [$];
    int        live_payloads [$];
    int        old_payloads [$];

    bit        quiet = 1'b0;
    t_heap_cmd drive_word;
    int        send_gap = 0;
    int        hold_left = 0;
    int        idle_cycles = 0;
    int        mismatches = 0;
    int        words_taken = 0;
    int        results_seen = 0;
    int        n_placed = 0, n_refused = 0, n_freed = 0, n_dbl = 0, n_range = 0;
    int        n_merge = 0, n_layouts = 0;

    function automatic int blk_bytes(int w);
        return int'({heap_hdr[w % HW][HDR_W-1:3], 3'b000});
    endfunction

    function automatic bit blk_taken(int w);
        return heap_hdr[w % HW][0];
    endfunction

    function automatic int next_hdr(int w);
        int len;
        int n;
        len = blk_bytes(w);
        n = w + len / 4;
        if (len == 0 || n > sent_word) begin
            return sent_word;
        end
        return n;
    endfunction

    function automatic void set_hdr(int w, int val);
        heap_hdr[w % HW] = HDR_W'(val);
        hdr_written[w % HW] = 1'b1;
    endfunction

    function automatic void lay_down();
        int sz;
        int total;
        sz = heap_size_req;
        if (sz > MAX_HEAP_BYTES) begin
            sz = MAX_HEAP_BYTES;
        end
        if (sz > HW * 4 - INIT_OVH) begin
            sz = HW * 4 - INIT_OVH;
        end
        total = (sz + INIT_OVH + ALIGN_MASK) & ~ALIGN_MASK;
        set_hdr(1, total - MIN_BLOCK);
        sent_word = 1 + (total - MIN_BLOCK) / 4;
        set_hdr(sent_word, 0);
        relay_due = 1'b0;
        n_layouts++;
    endfunction

    function automatic t_status place(int req, output int pay);
        int need;
        int w;
        int len;
        pay = 0;
        need = (req + HDR_BYTES + ALIGN_MASK) & ~ALIGN_MASK;
        w = 1;
        while (w != sent_word && (blk_bytes(w) < need || blk_taken(w))) begin
            w = next_hdr(w);
        end
        if (w == sent_word) begin
            return ST_NOSPACE;
        end
        len = blk_bytes(w);
        if (len - need >= MIN_BLOCK) begin
            set_hdr(w, need);
            set_hdr(w + need / 4, len - need);
        end
        heap_hdr[w % HW][0] = 1'b1;
        pay = 4 * (w + 1);
        return ST_OK;
    endfunction

    function automatic t_status unmark(int off);
        int w;
        if ((off & ALIGN_MASK) != 0 || off < MIN_BLOCK) begin
            return ST_RANGE;
        end
        w = off / 4 - 1;
        if (w >= sent_word) begin
            return ST_RANGE;
        end
        if (!blk_taken(w)) begin
            return ST_DBLFREE;
        end
        heap_hdr[w % HW][0] = 1'b0;
        return ST_OK;
    endfunction

    function automatic void merge_free_runs();
        int w;
        int n;
        w = 1;
        if (w >= sent_word) begin
            return;
        end
        n = next_hdr(w);
        while (n != sent_word) begin
            if (!blk_taken(w) && !blk_taken(n)) begin
                heap_hdr[w % HW] = HDR_W'(blk_bytes(w) + blk_bytes(n));
            end else begin
                w = n;
            end
            n = next_hdr(w);
        end
    endfunction

    task automatic issue(t_mode m, int req, int off);
        t_heap_cmd c;
        t_status   st;
        int        pay;
        int        w;
        if (relay_due) begin
            lay_down();
        end
        w = off / 4 - 1;
        if (m == MD_FREE && (off & ALIGN_MASK) == 0 && off >= MIN_BLOCK && w < sent_word
            && !hdr_written[w % HW]) begin
            off = 1;
        end
        pay = 0;
        st = ST_OK;
        case (m)
            MD_ALLOC: begin
                st = place(req, pay);
                if (st == ST_OK) begin
                    live_payloads.push_back(pay);
                    n_placed++;
                end else begin
                    n_refused++;
                end
            end
            MD_FREE: begin
                st = unmark(off);
                case (st)
                    ST_OK: begin
                        old_payloads.push_back(off);
                        n_freed++;
                    end
                    ST_DBLFREE: n_dbl++;
                    default: n_range++;
                endcase
            end
            MD_MERGE: begin
                merge_free_runs();
                n_merge++;
            end
            default: ;
        endcase
        c.mode = m;
        c.req = BYTE_W'(req);
        c.off = BYTE_W'(off);
        pending_words.push_back(c);
        status_due.push_back(st);
    endtask

    function automatic int pick_size();
        int s;
        s = $urandom_range(0, 99);
        if (s < 30) begin
            return $urandom_range(0, 12);
        end else if (s < 70) begin
            return $urandom_range(0, 64);
        end else if (s < 90) begin
            return $urandom_range(0, 400);
        end else if (s < 97) begin
            return $urandom_range(0, MAX_HEAP_BYTES);
        end
        return $urandom_range(0, 4095);
    endfunction

    task automatic random_words(int count);
        int r;
        int idx;
        int off;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 80 && live_payloads.size() == 0)) begin
                issue(MD_ALLOC, pick_size(), $urandom_range(0, 4095));
            end else if (r < 80) begin
                idx = $urandom_range(0, live_payloads.size() - 1);
                off = live_payloads[idx];
                live_payloads.delete(idx);
                issue(MD_FREE, $urandom_range(0, 4095), off);
            end else if (r < 86) begin
                issue(MD_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else if (r < 90 && old_payloads.size() != 0) begin
                idx = $urandom_range(0, old_payloads.size() - 1);
                issue(MD_FREE, $urandom_range(0, 4095), old_payloads[idx]);
            end else if (r < 97) begin
                issue(MD_MERGE, $urandom_range(0, 4095), $urandom_range(0, 4095));
            end else begin
                issue(MD_NONE, $urandom_range(0, 4095), $urandom_range(0, 4095));
            end
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || status_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_heap(int val);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_heap_bytes <= BYTE_W'(val);
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        heap_size_req = val;
        relay_due = 1'b1;
        foreach (live_payloads[k]) begin
            old_payloads.push_back(live_payloads[k]);
        end
        live_payloads.delete();
        @(negedge i_clk);
    endtask

    task automatic check_status();
        t_status want;
        results_seen++;
        if (status_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: status %0d with nothing pending", results_seen, o_status);
            end
        end else begin
            want = status_due.pop_front();
            if (o_status !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: status expected %s (%0d) got %0d",
                             results_seen, want.name(), want, o_status);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                words_taken <= words_taken + 1;
            end
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_words.size() != 0) begin
                drive_word = pending_words.pop_front();
                i_mode <= drive_word.mode;
                i_request_bytes <= drive_word.req;
                i_payload_offset <= drive_word.off;
                i_in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_status();
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                i_out_stall <= 1'b1;
                hold_left <= $urandom_range(0, 11);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results pending",
                     idle_cycles, status_due.size());
            $display("first_fit_block_allocator: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(MD_NONE, 0, 0);
        issue(MD_ALLOC, 0, 0);
        issue(MD_ALLOC, MAX_HEAP_BYTES, 0);
        issue(MD_ALLOC, 4095, 4095);
        issue(MD_FREE, 0, 8);
        issue(MD_FREE, 4095, 8);
        issue(MD_FREE, 0, 0);
        issue(MD_FREE, 0, 4095);
        issue(MD_FREE, 0, 12);
        issue(MD_FREE, 0, 16);
        issue(MD_MERGE, 0, 0);
        issue(MD_ALLOC, 4080, 0);
        issue(MD_ALLOC, 0, 0);
        issue(MD_FREE, 0, 8);
        issue(MD_ALLOC, 4076, 0);
        issue(MD_ALLOC, 0, 0);
        issue(MD_FREE, 0, 4088);
        issue(MD_MERGE, 4095, 4095);
        issue(MD_ALLOC, 4080, 0);
        issue(MD_FREE, 0, 8);
        issue(MD_MERGE, 0, 0);
        issue(MD_ALLOC, 4080, 0);
        issue(MD_FREE, 0, 8);
        live_payloads.delete();
        random_words(220);

        write_heap(0);
        issue(MD_FREE, 0, 16);
        issue(MD_FREE, 0, 8);
        issue(MD_ALLOC, 0, 0);
        issue(MD_ALLOC, 0, 0);
        issue(MD_FREE, 0, 4088);
        issue(MD_MERGE, 0, 0);
        random_words(80);

        write_heap(4095);
        random_words(140);
        drain();
        random_words(140);

        write_heap(37);
        random_words(100);

        write_heap($urandom_range(0, 4095));
        random_words(220);

        write_heap(MAX_HEAP_BYTES);
        quiet = 1'b1;
        random_words(270);

        drain();
        repeat (32) @(posedge i_clk);
        $display("%0d words over %0d heap layouts, %0d results checked", words_taken,
                 n_layouts, results_seen);
        $display("placed %0d, refused %0d, freed %0d, already free %0d, out of heap %0d",
                 n_placed, n_refused, n_freed, n_dbl, n_range);
        $display("merges %0d", n_merge);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("first_fit_block_allocator: match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, status_due.size());
            $display("first_fit_block_allocator: mismatch");
        end
        $finish;
    end

endmodule
